### src/assert_macros.svh
// Assertion helpers, clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CAU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

  localparam int unsigned FIELD_BITS  = 32;
  localparam int unsigned PROD_BITS   = 64;
  localparam int unsigned QUOT_BITS   = 33;
  localparam int unsigned ROOT_STEPS  = 32;
  localparam int unsigned ITER_STAGES = QUOT_BITS;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_EQ  = 3'd5
  } cau_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } cau_status_e;

  typedef struct packed {
    logic                 neg;
    logic [PROD_BITS-1:0] m;
  } cau_smag_t;

  typedef struct packed {
    logic                  flag;
    logic [FIELD_BITS-1:0] val;
  } cau_sat_t;

  typedef struct packed {
    cau_op_e               op;
    logic [FIELD_BITS-1:0] rr;
    logic [FIELD_BITS-1:0] ri;
    logic                  eq;
    logic                  flag;
    logic                  dz;
    cau_smag_t             n_re;
    cau_smag_t             n_im;
    logic [PROD_BITS-1:0]  den;
    logic [PROD_BITS-1:0]  rem_re;
    logic [PROD_BITS-1:0]  rem_im;
    logic [QUOT_BITS-1:0]  q_re;
    logic [QUOT_BITS-1:0]  q_im;
    logic                  big_re;
    logic                  big_im;
    logic [PROD_BITS-1:0]  sx;
    logic [PROD_BITS-1:0]  sr;
  } cau_iter_t;

  // clamp a sign-magnitude value to a word of weff bits, sign-extended to the field
  function automatic cau_sat_t sat_word(logic neg, logic [PROD_BITS:0] m, logic big,
                                        int unsigned weff);
    logic [PROD_BITS:0] lim_neg;
    logic [PROD_BITS:0] lim_pos;
    logic [PROD_BITS:0] mm;
    cau_sat_t           r;
    lim_neg = (PROD_BITS+1)'(1) << (weff - 1);
    lim_pos = lim_neg - (PROD_BITS+1)'(1);
    mm      = m;
    r.flag  = 1'b0;
    if (neg) begin
      if (big || (m > lim_neg)) begin
        r.flag = 1'b1;
        mm     = lim_neg;
      end
      r.val = ~mm[FIELD_BITS-1:0] + FIELD_BITS'(1);
    end else begin
      if (big || (m > lim_pos)) begin
        r.flag = 1'b1;
        mm     = lim_pos;
      end
      r.val = mm[FIELD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### src/cau_if.sv
`timescale 1ns / 1ps
interface cau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic signed [31:0] a_re;
  logic signed [31:0] a_im;
  logic signed [31:0] b_re;
  logic signed [31:0] b_im;

  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic        is_equal;
  logic [1:0]  status;

  modport source (output valid, res_re, res_im, is_equal, status, input ready);
  modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

### src/cau_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cau_front #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cau_in_if.sink             req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cau_pkg::cau_iter_t data_o
);
  import cau_pkg::*;

  localparam int unsigned WEFF = (WORD_BITS > FIELD_BITS) ? FIELD_BITS : WORD_BITS;
  localparam int unsigned SH   = FIELD_BITS - WEFF;
  localparam int unsigned DW   = PROD_BITS + FRAC_BITS;
  localparam int unsigned NSTG = 4;
  localparam logic signed [FIELD_BITS:0] ADD_MAX =
    (FIELD_BITS+1)'(((PROD_BITS)'(1) << (WEFF - 1)) - (PROD_BITS)'(1));
  localparam logic signed [FIELD_BITS:0] ADD_MIN = ~ADD_MAX;

  typedef struct packed {
    cau_op_e               op;
    logic [FIELD_BITS-1:0] ar;
    logic [FIELD_BITS-1:0] ai;
    logic [FIELD_BITS-1:0] br;
    logic [FIELD_BITS-1:0] bi;
  } opnd_t;

  typedef struct packed {
    cau_op_e               op;
    logic [FIELD_BITS-1:0] rr;
    logic [FIELD_BITS-1:0] ri;
    logic                  eq;
    logic                  flag;
    cau_smag_t             p_rr;
    cau_smag_t             p_ii;
    cau_smag_t             p_ri;
    cau_smag_t             p_ir;
    logic [PROD_BITS-1:0]  p4;
    logic [PROD_BITS-1:0]  p5;
  } prod_t;

  typedef struct packed {
    cau_op_e               op;
    logic [FIELD_BITS-1:0] rr;
    logic [FIELD_BITS-1:0] ri;
    logic                  eq;
    logic                  flag;
    cau_smag_t             n_re;
    cau_smag_t             n_im;
    logic [PROD_BITS-1:0]  sq;
  } comb_t;

  function automatic logic [FIELD_BITS-1:0] sext_w(logic [FIELD_BITS-1:0] x);
    logic [FIELD_BITS-1:0] t;
    t = x << SH;
    return FIELD_BITS'($signed(t) >>> SH);
  endfunction

  function automatic logic [FIELD_BITS-1:0] mag32(logic [FIELD_BITS-1:0] x);
    return x[FIELD_BITS-1] ? (~x + FIELD_BITS'(1)) : x;
  endfunction

  function automatic cau_smag_t sadd(cau_smag_t x, cau_smag_t y);
    cau_smag_t r;
    if (x.neg == y.neg) begin
      r.m   = x.m + y.m;
      r.neg = x.neg;
    end else if (x.m >= y.m) begin
      r.m   = x.m - y.m;
      r.neg = x.neg;
    end else begin
      r.m   = y.m - x.m;
      r.neg = y.neg;
    end
    return r;
  endfunction

  function automatic cau_sat_t sat_add(logic signed [FIELD_BITS:0] s);
    cau_sat_t r;
    r.flag = 1'b0;
    r.val  = s[FIELD_BITS-1:0];
    if (s > ADD_MAX) begin
      r.flag = 1'b1;
      r.val  = ADD_MAX[FIELD_BITS-1:0];
    end else if (s < ADD_MIN) begin
      r.flag = 1'b1;
      r.val  = ADD_MIN[FIELD_BITS-1:0];
    end
    return r;
  endfunction

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;
  opnd_t     s1_q, s1_d;
  prod_t     s2_q, s2_d;
  comb_t     s3_q, s3_d;
  cau_iter_t s4_q, s4_d;

  assign en[3] = !v_q[3] || ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign req_i.ready = en[0];
  assign valid_o = v_q[3];
  assign data_o  = s4_q;

  // operand capture
  always_comb begin
    s1_d.op = cau_op_e'(req_i.op);
    s1_d.ar = sext_w(req_i.a_re);
    s1_d.ai = sext_w(req_i.a_im);
    s1_d.br = sext_w(req_i.b_re);
    s1_d.bi = sext_w(req_i.b_im);
  end

  // products, add and subtract, equality
  logic [FIELD_BITS-1:0] m_ar, m_ai, m_br, m_bi, sq_x, sq_y;
  logic signed [FIELD_BITS:0] e_ar, e_ai, e_br, e_bi, sum_re, sum_im;
  cau_sat_t sat_re, sat_im;

  always_comb begin
    m_ar = mag32(s1_q.ar);
    m_ai = mag32(s1_q.ai);
    m_br = mag32(s1_q.br);
    m_bi = mag32(s1_q.bi);
    sq_x = (s1_q.op == OP_MAG) ? m_ar : m_br;
    sq_y = (s1_q.op == OP_MAG) ? m_ai : m_bi;
    e_ar = $signed({s1_q.ar[FIELD_BITS-1], s1_q.ar});
    e_ai = $signed({s1_q.ai[FIELD_BITS-1], s1_q.ai});
    e_br = $signed({s1_q.br[FIELD_BITS-1], s1_q.br});
    e_bi = $signed({s1_q.bi[FIELD_BITS-1], s1_q.bi});
    sum_re = (s1_q.op == OP_SUB) ? (e_ar - e_br) : (e_ar + e_br);
    sum_im = (s1_q.op == OP_SUB) ? (e_ai - e_bi) : (e_ai + e_bi);
    sat_re = sat_add(sum_re);
    sat_im = sat_add(sum_im);

    s2_d.op   = s1_q.op;
    s2_d.rr   = '0;
    s2_d.ri   = '0;
    s2_d.flag = 1'b0;
    s2_d.eq   = (s1_q.op == OP_EQ) && (s1_q.ar == s1_q.br) && (s1_q.ai == s1_q.bi);
    if ((s1_q.op == OP_ADD) || (s1_q.op == OP_SUB)) begin
      s2_d.rr   = sat_re.val;
      s2_d.ri   = sat_im.val;
      s2_d.flag = sat_re.flag || sat_im.flag;
    end
    s2_d.p_rr.m   = PROD_BITS'(m_ar) * PROD_BITS'(m_br);
    s2_d.p_rr.neg = s1_q.ar[FIELD_BITS-1] ^ s1_q.br[FIELD_BITS-1];
    s2_d.p_ii.m   = PROD_BITS'(m_ai) * PROD_BITS'(m_bi);
    s2_d.p_ii.neg = s1_q.ai[FIELD_BITS-1] ^ s1_q.bi[FIELD_BITS-1];
    s2_d.p_ri.m   = PROD_BITS'(m_ar) * PROD_BITS'(m_bi);
    s2_d.p_ri.neg = s1_q.ar[FIELD_BITS-1] ^ s1_q.bi[FIELD_BITS-1];
    s2_d.p_ir.m   = PROD_BITS'(m_ai) * PROD_BITS'(m_br);
    s2_d.p_ir.neg = s1_q.ai[FIELD_BITS-1] ^ s1_q.br[FIELD_BITS-1];
    s2_d.p4       = PROD_BITS'(sq_x) * PROD_BITS'(sq_x);
    s2_d.p5       = PROD_BITS'(sq_y) * PROD_BITS'(sq_y);
  end

  // cross sums; divide takes the conjugate of b
  cau_smag_t x_re, y_re, x_im, y_im;

  always_comb begin
    x_re = s2_q.p_rr;
    if (s2_q.op == OP_DIV) begin
      y_re = s2_q.p_ii;
      x_im = s2_q.p_ir;
      y_im = '{neg: !s2_q.p_ri.neg, m: s2_q.p_ri.m};
    end else begin
      y_re = '{neg: !s2_q.p_ii.neg, m: s2_q.p_ii.m};
      x_im = s2_q.p_ri;
      y_im = s2_q.p_ir;
    end
    s3_d.op   = s2_q.op;
    s3_d.rr   = s2_q.rr;
    s3_d.ri   = s2_q.ri;
    s3_d.eq   = s2_q.eq;
    s3_d.flag = s2_q.flag;
    s3_d.n_re = sadd(x_re, y_re);
    s3_d.n_im = sadd(x_im, y_im);
    s3_d.sq   = s2_q.p4 + s2_q.p5;
  end

  // product rounding, divider and root set-up
  logic [PROD_BITS:0] rnd_re, rnd_im;
  cau_sat_t           ps_re, ps_im;
  logic [DW-1:0]      top_re, top_im, den_w;

  always_comb begin
    rnd_re = ({1'b0, s3_q.n_re.m} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_im = ({1'b0, s3_q.n_im.m} + ((PROD_BITS+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    ps_re  = sat_word(s3_q.n_re.neg, rnd_re, 1'b0, WEFF);
    ps_im  = sat_word(s3_q.n_im.neg, rnd_im, 1'b0, WEFF);
    top_re = {s3_q.n_re.m, {FRAC_BITS{1'b0}}} >> QUOT_BITS;
    top_im = {s3_q.n_im.m, {FRAC_BITS{1'b0}}} >> QUOT_BITS;
    den_w  = {{FRAC_BITS{1'b0}}, s3_q.sq};

    s4_d.op   = s3_q.op;
    s4_d.rr   = s3_q.rr;
    s4_d.ri   = s3_q.ri;
    s4_d.eq   = s3_q.eq;
    s4_d.flag = s3_q.flag;
    if (s3_q.op == OP_MUL) begin
      s4_d.rr   = ps_re.val;
      s4_d.ri   = ps_im.val;
      s4_d.flag = ps_re.flag || ps_im.flag;
    end
    s4_d.dz     = (s3_q.sq == '0);
    s4_d.n_re   = s3_q.n_re;
    s4_d.n_im   = s3_q.n_im;
    s4_d.den    = s3_q.sq;
    s4_d.big_re = (top_re >= den_w);
    s4_d.big_im = (top_im >= den_w);
    s4_d.rem_re = top_re[PROD_BITS-1:0];
    s4_d.rem_im = top_im[PROD_BITS-1:0];
    s4_d.q_re   = '0;
    s4_d.q_im   = '0;
    s4_d.sx     = s3_q.sq;
    s4_d.sr     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= req_i.valid;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && req_i.valid) s1_q <= s1_d;
    if (en[1] && v_q[0])      s2_q <= s2_d;
    if (en[2] && v_q[1])      s3_q <= s3_d;
    if (en[3] && v_q[2])      s4_q <= s4_d;
  end

  `CAU_ASSERT(a_front_hold, v_q[3] && !ready_i |=> v_q[3] && $stable(s4_q), "front item lost")

endmodule

### src/cau_iter_stage.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cau_iter_stage #(
  parameter int unsigned STEP      = 0,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cau_pkg::cau_iter_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cau_pkg::cau_iter_t data_o
);
  import cau_pkg::*;

  localparam int unsigned DIV_BIT = QUOT_BITS - 1 - STEP;

  logic      valid_q;
  cau_iter_t data_q, data_d;
  logic      b_re, b_im;
  logic [PROD_BITS-1:0] sx_n, sr_n;
  logic [PROD_BITS:0]   t_re, t_im, df_re, df_im;
  logic                 ge_re, ge_im;

  // next dividend bit of num * 2^FRAC_BITS
  if (DIV_BIT >= FRAC_BITS) begin : g_num
    assign b_re = data_i.n_re.m[DIV_BIT - FRAC_BITS];
    assign b_im = data_i.n_im.m[DIV_BIT - FRAC_BITS];
  end else begin : g_zero
    assign b_re = 1'b0;
    assign b_im = 1'b0;
  end

  if (STEP < ROOT_STEPS) begin : g_root
    localparam logic [PROD_BITS-1:0] ROOT_BIT =
      PROD_BITS'(1) << (2 * (ROOT_STEPS - 1 - STEP));
    logic [PROD_BITS-1:0] trial;
    logic                 take;
    assign trial = data_i.sr + ROOT_BIT;
    assign take  = data_i.sx >= trial;
    assign sx_n  = take ? (data_i.sx - trial) : data_i.sx;
    assign sr_n  = take ? ((data_i.sr >> 1) + ROOT_BIT) : (data_i.sr >> 1);
  end else begin : g_noroot
    assign sx_n = data_i.sx;
    assign sr_n = data_i.sr;
  end

  always_comb begin
    t_re  = {data_i.rem_re, b_re};
    t_im  = {data_i.rem_im, b_im};
    ge_re = t_re >= {1'b0, data_i.den};
    ge_im = t_im >= {1'b0, data_i.den};
    df_re = t_re - {1'b0, data_i.den};
    df_im = t_im - {1'b0, data_i.den};

    data_d        = data_i;
    data_d.rem_re = ge_re ? df_re[PROD_BITS-1:0] : t_re[PROD_BITS-1:0];
    data_d.rem_im = ge_im ? df_im[PROD_BITS-1:0] : t_im[PROD_BITS-1:0];
    data_d.q_re   = {data_i.q_re[QUOT_BITS-2:0], ge_re};
    data_d.q_im   = {data_i.q_im[QUOT_BITS-2:0], ge_im};
    data_d.sx     = sx_n;
    data_d.sr     = sr_n;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  `CAU_ASSERT(a_iter_hold, valid_q && !ready_i |=> valid_q && $stable(data_q), "stage item lost")

endmodule

### src/cau_final.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cau_final #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cau_pkg::cau_iter_t data_i,
  cau_out_if.source          rsp_o
);
  import cau_pkg::*;

  localparam int unsigned WEFF = (WORD_BITS > FIELD_BITS) ? FIELD_BITS : WORD_BITS;

  logic                  valid_q;
  logic [FIELD_BITS-1:0] re_q, im_q, re_d, im_d;
  logic                  eq_q, eq_d;
  cau_status_e           st_q, st_d;
  logic                  up_re, up_im;
  logic [QUOT_BITS:0]    qr_re, qr_im;
  logic [PROD_BITS:0]    root;
  cau_sat_t              ds_re, ds_im, rs;

  always_comb begin
    up_re = {data_i.rem_re, 1'b0} >= {1'b0, data_i.den};
    up_im = {data_i.rem_im, 1'b0} >= {1'b0, data_i.den};
    qr_re = {1'b0, data_i.q_re} + {{QUOT_BITS{1'b0}}, up_re};
    qr_im = {1'b0, data_i.q_im} + {{QUOT_BITS{1'b0}}, up_im};
    ds_re = sat_word(data_i.n_re.neg, (PROD_BITS+1)'(qr_re), data_i.big_re, WEFF);
    ds_im = sat_word(data_i.n_im.neg, (PROD_BITS+1)'(qr_im), data_i.big_im, WEFF);
    root  = {1'b0, data_i.sr} + {{PROD_BITS{1'b0}}, (data_i.sx > data_i.sr)};
    rs    = sat_word(1'b0, root, 1'b0, WEFF);

    re_d = '0;
    im_d = '0;
    eq_d = 1'b0;
    st_d = ST_OK;
    case (data_i.op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_EQ: begin
        re_d = data_i.rr;
        im_d = data_i.ri;
        eq_d = data_i.eq;
        st_d = data_i.flag ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (data_i.dz) begin
          st_d = ST_DIV_ZERO;
        end else begin
          re_d = ds_re.val;
          im_d = ds_im.val;
          st_d = (ds_re.flag || ds_im.flag) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        re_d = rs.val;
        st_d = rs.flag ? ST_SAT : ST_OK;
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  assign ready_o        = !valid_q || rsp_o.ready;
  assign rsp_o.valid    = valid_q;
  assign rsp_o.res_re   = re_q;
  assign rsp_o.res_im   = im_q;
  assign rsp_o.is_equal = eq_q;
  assign rsp_o.status   = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      re_q <= re_d;
      im_q <= im_d;
      eq_q <= eq_d;
      st_q <= st_d;
    end
  end

  `CAU_ASSERT(a_dz_zero, rsp_o.valid && (rsp_o.status == ST_DIV_ZERO) |-> (rsp_o.res_re == '0) && (rsp_o.res_im == '0), "divide by zero gave a value")
  `CAU_NEVER(a_eq_clean, rsp_o.valid && rsp_o.is_equal && ((rsp_o.status != ST_OK) || (rsp_o.res_re != '0)), "equality item not clean")

endmodule

### src/complex_arith_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// req_i    in   valid/ready, item    op, a_re, a_im, b_re, b_im
// rsp_o    out  valid/ready, item    res_re, res_im, is_equal, status
//
// One item per cycle unless rsp_o stalls. Pipeline: four front stages (operands,
// products, cross sums, rounding and divider set-up), 33 divide/root step
// stages, one output register. The divide loop sets the depth; the root loop needs fewer steps.
// rst_ni clears every valid bit; payload registers hold no reset.
// Each stage holds while its successor is full and stalled; bubbles close up.
module complex_arith_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    req_i,
  cau_out_if.source rsp_o
);
  import cau_pkg::*;

  logic [ITER_STAGES:0] v;
  logic [ITER_STAGES:0] rdy;
  cau_iter_t            d [ITER_STAGES+1];

  cau_front #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .valid_o(v[0]),
    .ready_i(rdy[0]),
    .data_o (d[0])
  );

  for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
    cau_iter_stage #(
      .STEP(k),
      .FRAC_BITS(FRAC_BITS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v[k]),
      .ready_o(rdy[k]),
      .data_i (d[k]),
      .valid_o(v[k+1]),
      .ready_i(rdy[k+1]),
      .data_o (d[k+1])
    );
  end

  cau_final #(
    .WORD_BITS(WORD_BITS)
  ) u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v[ITER_STAGES]),
    .ready_o(rdy[ITER_STAGES]),
    .data_i (d[ITER_STAGES]),
    .rsp_o  (rsp_o)
  );

endmodule
